// ===== rtl/blpe_pkg.sv =====
// Package of constants, codes and control types shared by the binary panel block.
`timescale 1ns / 1ps
`default_nettype none

package blpe_pkg;

	// Widths of the item fields.
	localparam int CMD_W = 2;
	localparam int ROW_W = 8;
	localparam int COL_W = 10;
	localparam int LEN_W = 11;

	// The panel is stored as words of WORD_BITS columns of one row.
	localparam int WORD_BITS = 16;
	localparam int BIT_W = $clog2(WORD_BITS);
	localparam int WIDX_W = COL_W - BIT_W;

	localparam int ROW_COUNT_DEF = 256;
	localparam int COLUMN_COUNT_DEF = 1024;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE  = 2'd0,
		CMD_EXTEND = 2'd1,
		CMD_WINDOW = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_WRITE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear_en;
		logic accept;
		logic wr_en;
		logic scan_en;
		logic load;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		cmd_t cmd;
		logic len_zero;
		logic scan_hit;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/blpe_in_if.sv =====
// Request channel of the binary panel block: handshake and command fields.
`timescale 1ns / 1ps
`default_nettype none

interface blpe_in_if;
	logic                       valid;
	logic                       ready;
	logic [blpe_pkg::CMD_W-1:0] command;
	logic [blpe_pkg::ROW_W-1:0] row_a;
	logic [blpe_pkg::ROW_W-1:0] row_b;
	logic [blpe_pkg::COL_W-1:0] end_column;
	logic [blpe_pkg::LEN_W-1:0] window_length;
	logic                       bit_value;

	modport source (
		output valid, command, row_a, row_b, end_column, window_length, bit_value,
		input  ready
	);
	modport sink (
		input  valid, command, row_a, row_b, end_column, window_length, bit_value,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/blpe_out_if.sv =====
// Response channel of the binary panel block: handshake and result fields.
`timescale 1ns / 1ps
`default_nettype none

interface blpe_out_if;
	logic                       valid;
	logic                       ready;
	logic [blpe_pkg::LEN_W-1:0] match_length;
	logic                       window_equal;

	modport source (
		output valid, match_length, window_equal,
		input  ready
	);
	modport sink (
		input  valid, match_length, window_equal,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/blpe_ram.sv =====
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module blpe_ram #(
	parameter int WIDTH  = 16,
	parameter int DEPTH  = 16384,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr_a,
	output logic      [WIDTH-1:0]  rdata_a,
	input  wire logic [ADDR_W-1:0] raddr_b,
	output logic      [WIDTH-1:0]  rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

// ===== rtl/blpe_ctrl.sv =====
// Controller state machine of the binary panel block.
`timescale 1ns / 1ps
`default_nettype none

module blpe_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire blpe_pkg::dp_stat_t    stat,
	output blpe_pkg::ctrl_cmd_t        cmd
);
	import blpe_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (stat.clear_last) state_next = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_next = ST_DECODE;
			end
			ST_DECODE: begin
				case (stat.cmd)
					CMD_WRITE:  state_next = ST_WRITE;
					CMD_EXTEND: state_next = ST_SCAN;
					CMD_WINDOW: state_next = stat.len_zero ? ST_FINISH : ST_SCAN;
					default:    state_next = ST_FINISH;
				endcase
			end
			ST_WRITE: begin
				state_next = ST_FINISH;
			end
			ST_SCAN: begin
				if (stat.scan_hit) state_next = ST_FINISH;
			end
			ST_FINISH: begin
				if (stat.out_free) state_next = ST_IDLE;
			end
			default: state_next = ST_CLEAR;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		cmd.clear_en = (state_q == ST_CLEAR);
		cmd.accept   = (state_q == ST_IDLE) && in_valid;
		cmd.wr_en    = (state_q == ST_WRITE);
		cmd.scan_en  = (state_q == ST_SCAN);
		cmd.load     = (state_q == ST_FINISH) && stat.out_free;
	end

endmodule

`default_nettype wire

// ===== rtl/blpe_dp.sv =====
// Datapath of the binary panel block: panel RAM, word scan, result register.
`timescale 1ns / 1ps
`default_nettype none

module blpe_dp #(
	parameter int ROW_COUNT    = blpe_pkg::ROW_COUNT_DEF,
	parameter int COLUMN_COUNT = blpe_pkg::COLUMN_COUNT_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire blpe_pkg::ctrl_cmd_t        cmd,
	output blpe_pkg::dp_stat_t              stat,
	input  wire logic [blpe_pkg::CMD_W-1:0] command,
	input  wire logic [blpe_pkg::ROW_W-1:0] row_a,
	input  wire logic [blpe_pkg::ROW_W-1:0] row_b,
	input  wire logic [blpe_pkg::COL_W-1:0] end_column,
	input  wire logic [blpe_pkg::LEN_W-1:0] window_length,
	input  wire logic                       bit_value,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic      [blpe_pkg::LEN_W-1:0] match_length,
	output logic                            window_equal
);
	import blpe_pkg::*;

	// Only rows and columns that the fields can reach are stored.
	localparam int ROW_SPAN = 1 << ROW_W;
	localparam int COL_SPAN = 1 << COL_W;
	localparam int ROWS_USED = (ROW_COUNT < ROW_SPAN) ? ROW_COUNT : ROW_SPAN;
	localparam int COLS_USED = (COLUMN_COUNT < COL_SPAN) ? COLUMN_COUNT : COL_SPAN;
	localparam int WPR = (COLS_USED + WORD_BITS - 1) / WORD_BITS;
	localparam int DEPTH = ROWS_USED * WPR;
	localparam int ADDR_W = $clog2(DEPTH);

	localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

	cmd_t               cmd_q;
	logic [ROW_W-1:0]   ra_q;
	logic [ROW_W-1:0]   rb_q;
	logic [COL_W-1:0]   end_q;
	logic [COL_W-1:0]   start_q;
	logic               len_zero_q;
	logic               bit_q;
	logic               a_zero_q;
	logic               b_zero_q;

	logic [WIDX_W-1:0]  iss_w_q;
	logic               iss_act_q;
	logic [WIDX_W-1:0]  ev_w_q;
	logic               ev_valid_q;

	logic [ADDR_W-1:0]  clr_q;
	logic [LEN_W-1:0]   res_len_q;
	logic               res_eq_q;
	logic               out_valid_q;
	logic [LEN_W-1:0]   match_length_q;
	logic               window_equal_q;

	logic [COL_W-1:0]     start_in;
	logic [ADDR_W-1:0]    addr_a;
	logic [ADDR_W-1:0]    addr_b;
	logic                 word_ok;
	logic                 wr_ok;
	logic                 ram_we;
	logic [ADDR_W-1:0]    ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [WORD_BITS-1:0] rdata_a;
	logic [WORD_BITS-1:0] rdata_b;
	logic [WORD_BITS-1:0] set_word;
	logic                 ev_oob;
	logic [WORD_BITS-1:0] word_a;
	logic [WORD_BITS-1:0] word_b;
	logic [WORD_BITS-1:0] hi_mask;
	logic [WORD_BITS-1:0] lo_mask;
	logic [WORD_BITS-1:0] diff;
	logic [BIT_W-1:0]     top_bit;
	logic [COL_W-1:0]     miss_col;
	logic                 at_start;
	logic                 scan_hit;

	// Window start, clamped at column zero; the extension always runs to zero.
	always_comb begin
		start_in = '0;
		if (cmd_t'(command) == CMD_WINDOW && window_length <= {1'b0, end_column}
				&& window_length != '0) begin
			start_in = COL_W'({1'b0, end_column} - window_length + LEN_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q      <= cmd_t'(command);
			ra_q       <= row_a;
			rb_q       <= row_b;
			end_q      <= end_column;
			start_q    <= start_in;
			len_zero_q <= (window_length == '0);
			bit_q      <= bit_value;
			a_zero_q   <= (32'(row_a) >= ROWS_USED);
			b_zero_q   <= (32'(row_b) >= ROWS_USED);
		end
	end

	// Word addresses of both rows at the word being issued.
	assign word_ok = (32'(iss_w_q) < WPR);

	always_comb begin
		addr_a = '0;
		addr_b = '0;
		if (word_ok && !a_zero_q) begin
			addr_a = ADDR_W'(ADDR_W'(ra_q) * ADDR_W'(WPR)) + ADDR_W'(iss_w_q);
		end
		if (word_ok && !b_zero_q) begin
			addr_b = ADDR_W'(ADDR_W'(rb_q) * ADDR_W'(WPR)) + ADDR_W'(iss_w_q);
		end
	end

	// A write reads its word while the command is decoded and writes it back next.
	always_comb begin
		set_word = rdata_a;
		set_word[end_q[BIT_W-1:0]] = bit_q;
	end

	assign wr_ok = !a_zero_q && (32'(end_q) < COLS_USED);
	assign ram_we = cmd.clear_en || (cmd.wr_en && wr_ok);
	assign ram_waddr = cmd.clear_en ? clr_q : addr_a;
	assign ram_wdata = cmd.clear_en ? '0 : set_word;

	blpe_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W)
	) u_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.raddr_a(addr_a),
		.rdata_a(rdata_a),
		.raddr_b(addr_b),
		.rdata_b(rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_en) begin
			clr_q <= clr_q + ADDR_W'(1);
		end
	end

	// Scan pipeline: one word issued per cycle, its data evaluated in the cycle after.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_w_q    <= '0;
			iss_act_q  <= 1'b0;
			ev_w_q     <= '0;
			ev_valid_q <= 1'b0;
		end else if (cmd.accept) begin
			iss_w_q    <= end_column[COL_W-1:BIT_W];
			iss_act_q  <= 1'b1;
			ev_valid_q <= 1'b0;
		end else if (cmd.scan_en) begin
			ev_w_q     <= iss_w_q;
			ev_valid_q <= iss_act_q;
			if (iss_act_q) begin
				if (iss_w_q != start_q[COL_W-1:BIT_W]) begin
					iss_w_q <= iss_w_q - WIDX_W'(1);
				end else begin
					iss_act_q <= 1'b0;
				end
			end
		end
	end

	// Cells outside the panel read as zero.
	assign ev_oob = (32'(ev_w_q) >= WPR);
	assign word_a = (a_zero_q || ev_oob) ? '0 : rdata_a;
	assign word_b = (b_zero_q || ev_oob) ? '0 : rdata_b;
	assign at_start = (ev_w_q == start_q[COL_W-1:BIT_W]);

	always_comb begin
		hi_mask = ONES;
		lo_mask = ONES;
		if (ev_w_q == end_q[COL_W-1:BIT_W]) begin
			hi_mask = ONES >> (BIT_W'(WORD_BITS - 1) - end_q[BIT_W-1:0]);
		end
		if (at_start) begin
			lo_mask = ONES << start_q[BIT_W-1:0];
		end
		diff = (word_a ^ word_b) & hi_mask & lo_mask;
	end

	// The highest differing bit is the mismatch nearest the end column.
	always_comb begin
		top_bit = '0;
		for (int p = 0; p < WORD_BITS; p++) begin
			if (diff[p]) top_bit = BIT_W'(p);
		end
	end

	assign miss_col = {ev_w_q, top_bit};
	assign scan_hit = cmd.scan_en && ev_valid_q && ((diff != '0) || at_start);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			res_len_q <= '0;
			res_eq_q  <= (cmd_t'(command) == CMD_WINDOW) && (window_length == '0);
		end else if (scan_hit) begin
			if (diff != '0) begin
				res_len_q <= (cmd_q == CMD_EXTEND) ? ({1'b0, end_q} - {1'b0, miss_col}) : '0;
				res_eq_q  <= 1'b0;
			end else begin
				res_len_q <= (cmd_q == CMD_EXTEND) ? ({1'b0, end_q} + LEN_W'(1)) : '0;
				res_eq_q  <= (cmd_q == CMD_WINDOW);
			end
		end
	end

	// Output register: a finished item waits here while the next one is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			match_length_q <= res_len_q;
			window_equal_q <= res_eq_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign match_length = match_length_q;
	assign window_equal = window_equal_q;

	always_comb begin
		stat.clear_last = (clr_q == ADDR_W'(DEPTH - 1));
		stat.cmd        = cmd_q;
		stat.len_zero   = len_zero_q;
		stat.scan_hit   = scan_hit;
		stat.out_free   = !out_valid_q || out_ready;
	end

endmodule

`default_nettype wire

// ===== rtl/binary_panel_left_extension.sv =====
// Binary panel with leftward extension and window checks, top level.
// After reset a clearing pass writes zero to every panel word, one word a cycle, and no
// item is taken then. An extension or window check reads one 16-bit word of both rows
// per cycle from the dual-read-port panel RAM. A write is a read-modify-write of one
// word; unused commands skip straight to finish. One item is worked on at a time; the
// output register lets the next item enter.
`timescale 1ns / 1ps
`default_nettype none

module binary_panel_left_extension #(
	parameter int ROW_COUNT    = blpe_pkg::ROW_COUNT_DEF,
	parameter int COLUMN_COUNT = blpe_pkg::COLUMN_COUNT_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	blpe_in_if.sink    request,
	blpe_out_if.source response
);
	import blpe_pkg::*;

	ctrl_cmd_t ctl_cmd;
	dp_stat_t  dp_stat;
	logic      in_ready;

	assign request.ready = in_ready;

	blpe_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(request.valid),
		.in_ready(in_ready),
		.stat    (dp_stat),
		.cmd     (ctl_cmd)
	);

	blpe_dp #(
		.ROW_COUNT   (ROW_COUNT),
		.COLUMN_COUNT(COLUMN_COUNT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (ctl_cmd),
		.stat         (dp_stat),
		.command      (request.command),
		.row_a        (request.row_a),
		.row_b        (request.row_b),
		.end_column   (request.end_column),
		.window_length(request.window_length),
		.bit_value    (request.bit_value),
		.out_valid    (response.valid),
		.out_ready    (response.ready),
		.match_length (response.match_length),
		.window_equal (response.window_equal)
	);

endmodule

`default_nettype wire
